[design/ordered_list_store_unit_macros.svh]
// Assertion macros used by the checker file of the ordered list store.
`ifndef ORDERED_LIST_STORE_UNIT_MACROS_SVH
`define ORDERED_LIST_STORE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define OLSU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define OLSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/olsu_pkg.sv]
// Types and constants of the ordered list store.
package olsu_pkg;

    localparam int CAPACITY   = 64;
    localparam int ITEM_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = IDX_W + 1;
    localparam int EXT_W      = CNT_W + 1;

    typedef enum logic [1:0]
    {
        FUNC_APPEND,
        FUNC_REMOVE,
        FUNC_GET,
        FUNC_MOVE
    } func_t;

    typedef enum logic [1:0]
    {
        STAT_OK,
        STAT_NOT_FOUND,
        STAT_RANGE,
        STAT_FULL
    } status_t;

    typedef enum logic [2:0]
    {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SCAN,
        CELL_SHIFT,
        CELL_ROTATE
    } cell_op_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_ROTATE,
        ST_REPLY
    } state_t;

    typedef struct packed
    {
        cell_op_t              op;
        logic [ITEM_WIDTH-1:0] key;
        logic [ITEM_WIDTH-1:0] wrap;
        logic [IDX_W-1:0]      target;
        logic [IDX_W-1:0]      lo;
        logic [IDX_W-1:0]      last;
        logic [CNT_W-1:0]      count;
    } cell_ctrl_t;

endpackage

[design/olsu_cell.sv]
// One list cell: a stored word and a match flag that ripples right one cell per cycle.
module olsu_cell
    import olsu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IDX_W-1:0]      cell_index,
    input  cell_ctrl_t            ctrl,
    input  logic [ITEM_WIDTH-1:0] right_word,
    input  logic                  seen_left,
    output logic [ITEM_WIDTH-1:0] word,
    output logic                  seen
);

    logic [ITEM_WIDTH-1:0] word_reg;
    logic [ITEM_WIDTH-1:0] word_next;
    logic                  seen_reg;
    logic                  seen_next;

    always_comb
    begin
        word_next = word_reg;
        seen_next = seen_reg;
        unique case (ctrl.op)
            CELL_HOLD:
            begin
                word_next = word_reg;
            end
            CELL_LOAD:
            begin
                if (cell_index == ctrl.target)
                begin
                    word_next = ctrl.key;
                end
            end
            CELL_SCAN:
            begin
                seen_next = seen_left |
                    ((word_reg == ctrl.key) && (CNT_W'(cell_index) < ctrl.count));
            end
            CELL_SHIFT:
            begin
                if (seen_reg && (cell_index < ctrl.last))
                begin
                    word_next = right_word;
                end
            end
            CELL_ROTATE:
            begin
                if ((cell_index >= ctrl.lo) && (cell_index < ctrl.last))
                begin
                    word_next = right_word;
                end
                else if (cell_index == ctrl.last)
                begin
                    word_next = ctrl.wrap;
                end
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
        end
        else
        begin
            seen_reg <= seen_next;
        end
    end

    assign word = word_reg;
    assign seen = seen_reg;

endmodule

[design/ordered_list_store_unit.sv]
// Ordered list store: up to 64 words held in a row of cells, with append, remove, get, move.
//
// Input channel (in_valid/in_ready) takes one beat per operation: func, item_word,
// position, move_count, destination. Output channel (out_valid/out_ready) returns one
// beat per operation: status, read_word, list_length.
// Steps from input beat to output beat, each ending in the reply state:
//   append, get, failed move, move onto itself: no further steps
//   remove: a scan of the whole cell row, in which the match flag ripples through it, then a shift
//   move: rotation steps, where a step rotates the affected span by one cell;
//         steps = move_count for a later destination, else position - destination
// One operation is in flight at a time; in_ready is high only while idle.
// A new operation is taken only after the last result has gone into the output register.
// The result sits in an output register: a new beat is taken while it waits,
// and the finished result of that beat waits in turn until out_ready frees it.
// Reset empties the list (length zero) and drops any pending result; the stored
// words themselves are not cleared.
module ordered_list_store_unit
    import olsu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            func,
    input  logic [ITEM_WIDTH-1:0] item_word,
    input  logic [IDX_W-1:0]      position,
    input  logic [CNT_W-1:0]      move_count,
    input  logic [IDX_W-1:0]      destination,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            status,
    output logic [ITEM_WIDTH-1:0] read_word,
    output logic [CNT_W-1:0]      list_length
);

    state_t                state_reg;
    state_t                state_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [CNT_W-1:0]      step_reg;
    logic [CNT_W-1:0]      step_next;
    logic [IDX_W-1:0]      lo_reg;
    logic [IDX_W-1:0]      lo_next;
    logic [IDX_W-1:0]      last_reg;
    logic [IDX_W-1:0]      last_next;
    logic [ITEM_WIDTH-1:0] key_reg;
    logic [ITEM_WIDTH-1:0] key_next;
    status_t               res_status_reg;
    status_t               res_status_next;
    logic [ITEM_WIDTH-1:0] res_word_reg;
    logic [ITEM_WIDTH-1:0] res_word_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [1:0]            status_reg;
    logic [1:0]            status_next;
    logic [ITEM_WIDTH-1:0] read_word_reg;
    logic [ITEM_WIDTH-1:0] read_word_next;
    logic [CNT_W-1:0]      list_length_reg;
    logic [CNT_W-1:0]      list_length_next;

    cell_ctrl_t            ctrl;
    logic [ITEM_WIDTH-1:0] cell_word [CAPACITY];
    logic                  cell_seen [CAPACITY];
    logic [IDX_W-1:0]      rd_addr;
    logic [ITEM_WIDTH-1:0] rd_word;

    logic [EXT_W-1:0]      pos_ext;
    logic [EXT_W-1:0]      dest_ext;
    logic [EXT_W-1:0]      cnt_ext;
    logic [EXT_W-1:0]      len_ext;
    logic                  move_bad;
    logic                  dest_later;
    logic [EXT_W-1:0]      span_hi;
    logic [EXT_W-1:0]      span_last;
    logic [IDX_W-1:0]      back_dist;
    logic [CNT_W-1:0]      rot_amount;
    logic [CNT_W-1:0]      count_m1;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [ITEM_WIDTH-1:0] right_word;
            logic                  seen_left;
            if (gi == CAPACITY - 1)
            begin : g_tail
                assign right_word = cell_word[gi];
            end
            else
            begin : g_body
                assign right_word = cell_word[gi+1];
            end
            if (gi == 0)
            begin : g_head
                assign seen_left = 1'b0;
            end
            else
            begin : g_rest
                assign seen_left = cell_seen[gi-1];
            end
            olsu_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .cell_index (IDX_W'(gi)),
                .ctrl       (ctrl),
                .right_word (right_word),
                .seen_left  (seen_left),
                .word       (cell_word[gi]),
                .seen       (cell_seen[gi])
            );
        end
    endgenerate

    assign rd_addr = (state_reg == ST_IDLE) ? position : lo_reg;
    assign rd_word = cell_word[rd_addr];

    assign pos_ext    = EXT_W'(position);
    assign dest_ext   = EXT_W'(destination);
    assign cnt_ext    = EXT_W'(move_count);
    assign len_ext    = EXT_W'(count_reg);
    assign move_bad   = (pos_ext >= len_ext) || (dest_ext >= len_ext) ||
                        (move_count == '0) || ((pos_ext + cnt_ext) > len_ext) ||
                        ((dest_ext + cnt_ext) > len_ext);
    assign dest_later = destination > position;
    assign span_hi    = (dest_later ? dest_ext : pos_ext) + cnt_ext;
    assign span_last  = span_hi - EXT_W'(1);
    assign back_dist  = position - destination;
    assign rot_amount = dest_later ? move_count : CNT_W'(back_dist);
    assign count_m1   = count_reg - CNT_W'(1);

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        step_next        = step_reg;
        lo_next          = lo_reg;
        last_next        = last_reg;
        key_next         = key_reg;
        res_status_next  = res_status_reg;
        res_word_next    = res_word_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        status_next      = status_reg;
        read_word_next   = read_word_reg;
        list_length_next = list_length_reg;

        ctrl.op     = CELL_HOLD;
        ctrl.key    = (state_reg == ST_IDLE) ? item_word : key_reg;
        ctrl.wrap   = rd_word;
        ctrl.target = count_reg[IDX_W-1:0];
        ctrl.lo     = lo_reg;
        ctrl.last   = last_reg;
        ctrl.count  = count_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    res_word_next = '0;
                    unique case (func_t'(func))
                        FUNC_APPEND:
                        begin
                            if (count_reg < CNT_W'(CAPACITY))
                            begin
                                ctrl.op         = CELL_LOAD;
                                count_next      = count_reg + CNT_W'(1);
                                res_status_next = STAT_OK;
                            end
                            else
                            begin
                                res_status_next = STAT_FULL;
                            end
                            state_next = ST_REPLY;
                        end
                        FUNC_REMOVE:
                        begin
                            key_next   = item_word;
                            step_next  = '0;
                            state_next = ST_SCAN;
                        end
                        FUNC_GET:
                        begin
                            if (pos_ext < len_ext)
                            begin
                                res_status_next = STAT_OK;
                                res_word_next   = rd_word;
                            end
                            else
                            begin
                                res_status_next = STAT_RANGE;
                            end
                            state_next = ST_REPLY;
                        end
                        FUNC_MOVE:
                        begin
                            if (move_bad)
                            begin
                                res_status_next = STAT_RANGE;
                                state_next      = ST_REPLY;
                            end
                            else if (position == destination)
                            begin
                                res_status_next = STAT_OK;
                                state_next      = ST_REPLY;
                            end
                            else
                            begin
                                lo_next         = dest_later ? position : destination;
                                last_next       = span_last[IDX_W-1:0];
                                step_next       = rot_amount;
                                res_status_next = STAT_OK;
                                state_next      = ST_ROTATE;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                ctrl.op   = CELL_SCAN;
                step_next = step_reg + CNT_W'(1);
                if (step_reg == CNT_W'(CAPACITY - 1))
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                ctrl.last = count_m1[IDX_W-1:0];
                if (cell_seen[CAPACITY-1])
                begin
                    ctrl.op         = CELL_SHIFT;
                    count_next      = count_m1;
                    res_status_next = STAT_OK;
                end
                else
                begin
                    res_status_next = STAT_NOT_FOUND;
                end
                res_word_next = '0;
                state_next    = ST_REPLY;
            end
            ST_ROTATE:
            begin
                ctrl.op   = CELL_ROTATE;
                step_next = step_reg - CNT_W'(1);
                if (step_reg == CNT_W'(1))
                begin
                    state_next = ST_REPLY;
                end
            end
            ST_REPLY:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = res_status_reg;
                    read_word_next   = res_word_reg;
                    list_length_next = count_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg          <= lo_next;
        last_reg        <= last_next;
        key_reg         <= key_next;
        res_status_reg  <= res_status_next;
        res_word_reg    <= res_word_next;
        status_reg      <= status_next;
        read_word_reg   <= read_word_next;
        list_length_reg <= list_length_next;
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign read_word   = read_word_reg;
    assign list_length = list_length_reg;

endmodule

[design/olsu_checker.sv]
// Port-level checks for the ordered list store, bound to the top level.
`include "ordered_list_store_unit_macros.svh"

module olsu_checker
    import olsu_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic [1:0]            func,
    input logic [ITEM_WIDTH-1:0] item_word,
    input logic [IDX_W-1:0]      position,
    input logic [CNT_W-1:0]      move_count,
    input logic [IDX_W-1:0]      destination,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [1:0]            status,
    input logic [ITEM_WIDTH-1:0] read_word,
    input logic [CNT_W-1:0]      list_length
);

    `OLSU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(read_word) && $stable(list_length), "output beat changed while stalled")
    `OLSU_ASSERT_NOW(a_full_len, out_valid && (status == STAT_FULL), list_length == CNT_W'(CAPACITY), "full reported below capacity")
    `OLSU_ASSERT_NOW(a_word_zero, out_valid && (status != STAT_OK), read_word == '0, "nonzero word on failed operation")
    `OLSU_ASSERT_NEXT(a_busy_after, in_valid && in_ready, !in_ready, "ready right after an accepted beat")

endmodule

bind ordered_list_store_unit olsu_checker u_olsu_checker (.*);

[tb/sv/ordered_list_store_unit_tb.sv]
`timescale 1ns / 1ps
// Testbench for ordered_list_store_unit: directed and random list operations checked in order.
module ordered_list_store_unit_tb;
    import olsu_pkg::*;

    typedef struct {
        func_t                 f;
        logic [ITEM_WIDTH-1:0] word;
        logic [IDX_W-1:0]      pos;
        logic [CNT_W-1:0]      cnt;
        logic [IDX_W-1:0]      dst;
    } list_op_t;

    typedef struct {
        status_t               st;
        logic [ITEM_WIDTH-1:0] word;
        logic [CNT_W-1:0]      len;
    } list_reply_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [1:0]            func;
    logic [ITEM_WIDTH-1:0] item_word;
    logic [IDX_W-1:0]      position;
    logic [CNT_W-1:0]      move_count;
    logic [IDX_W-1:0]      destination;
    logic                  out_valid;
    logic                  out_ready;
    logic [1:0]            status;
    logic [ITEM_WIDTH-1:0] read_word;
    logic [CNT_W-1:0]      list_length;

    logic [ITEM_WIDTH-1:0] held_words[$];
    list_reply_t           pending_replies[$];
    int                    send_idle_pct;
    int                    recv_idle_pct;
    int                    mismatch_count;
    int                    block_idx;
    bit                    hold_off_req;

    ordered_list_store_unit dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .item_word   (item_word),
        .position    (position),
        .move_count  (move_count),
        .destination (destination),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .read_word   (read_word),
        .list_length (list_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #15_000_000;
        $display("tb: failure");
        $finish;
    end

    // list model: applies one operation and returns the reply it produces
    function automatic list_reply_t apply_list_op(list_op_t op);
        list_reply_t           r;
        int                    len;
        int                    idx;
        int                    s;
        int                    c;
        int                    d;
        logic [ITEM_WIDTH-1:0] blk[$];
        logic [ITEM_WIDTH-1:0] rest[$];
        r.st = STAT_OK;
        r.word = '0;
        len = held_words.size();
        s = int'(op.pos);
        c = int'(op.cnt);
        d = int'(op.dst);
        case (op.f)
            FUNC_APPEND:
            begin
                if (len >= CAPACITY)
                    r.st = STAT_FULL;
                else
                    held_words.push_back(op.word);
            end
            FUNC_REMOVE:
            begin
                idx = -1;
                for (int i = 0; i < len; i++)
                    if (idx < 0 && held_words[i] == op.word)
                        idx = i;
                if (idx < 0)
                    r.st = STAT_NOT_FOUND;
                else
                    held_words.delete(idx);
            end
            FUNC_GET:
            begin
                if (s < len)
                    r.word = held_words[s];
                else
                    r.st = STAT_RANGE;
            end
            default:
            begin
                if (s >= len || d >= len || c == 0 || s + c > len || d + c > len)
                    r.st = STAT_RANGE;
                else if (s != d)
                begin
                    for (int i = 0; i < len; i++)
                        if (i >= s && i < s + c)
                            blk.push_back(held_words[i]);
                        else
                            rest.push_back(held_words[i]);
                    held_words.delete();
                    for (int i = 0; i < d; i++)
                        held_words.push_back(rest[i]);
                    for (int i = 0; i < c; i++)
                        held_words.push_back(blk[i]);
                    for (int i = d; i < rest.size(); i++)
                        held_words.push_back(rest[i]);
                end
            end
        endcase
        r.len = CNT_W'(held_words.size());
        return r;
    endfunction

    function automatic list_op_t mk_op(func_t f, logic [ITEM_WIDTH-1:0] w, int p, int c, int d);
        list_op_t op;
        op.f = f;
        op.word = w;
        op.pos = IDX_W'(p);
        op.cnt = CNT_W'(c);
        op.dst = IDX_W'(d);
        return op;
    endfunction

    // random operation steering the length toward target
    function automatic list_op_t pick_op(int target);
        list_op_t op;
        int       len;
        int       r;
        int       a_pct;
        int       rm_pct;
        int       c;
        len = held_words.size();
        op.word = $urandom;
        op.pos = IDX_W'($urandom_range(63));
        op.cnt = CNT_W'($urandom_range(127));
        op.dst = IDX_W'($urandom_range(63));
        r = $urandom_range(3);
        if (r == 0)
            op.word = $urandom_range(7);
        else if (r == 1)
            op.word = $urandom_range(1) ? '1 : '0;
        if (len < target)
        begin
            a_pct = 65;
            rm_pct = 10;
        end
        else if (len > target)
        begin
            a_pct = 10;
            rm_pct = 55;
        end
        else
        begin
            a_pct = 35;
            rm_pct = 30;
        end
        r = $urandom_range(99);
        if (r < a_pct)
            op.f = FUNC_APPEND;
        else if (r < a_pct + rm_pct)
        begin
            op.f = FUNC_REMOVE;
            if (len > 0 && $urandom_range(9) < 7)
                op.word = held_words[$urandom_range(len - 1)];
        end
        else if (r < a_pct + rm_pct + (100 - a_pct - rm_pct) / 2)
        begin
            op.f = FUNC_GET;
            if (len > 0 && $urandom_range(9) < 8)
                op.pos = IDX_W'($urandom_range(len - 1));
        end
        else
        begin
            op.f = FUNC_MOVE;
            if (len > 0 && $urandom_range(3) != 0)
            begin
                if (len > 8 && $urandom_range(1) == 1)
                    c = $urandom_range(8, 1);
                else
                    c = $urandom_range(len, 1);
                op.cnt = CNT_W'(c);
                op.pos = IDX_W'($urandom_range(len - c));
                op.dst = IDX_W'($urandom_range(len - c));
            end
        end
        return op;
    endfunction

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_op(list_op_t op);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        func <= op.f;
        item_word <= op.word;
        position <= op.pos;
        move_count <= op.cnt;
        destination <= op.dst;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_replies.push_back(apply_list_op(op));
        @(negedge clk);
    endtask

    task automatic test_empty_list();
        send_idle_pct = 20;
        recv_idle_pct = 20;
        send_op(mk_op(FUNC_GET, 32'h0, 0, 1, 0));
        send_op(mk_op(FUNC_REMOVE, 32'h0, 0, 1, 0));
        send_op(mk_op(FUNC_MOVE, 32'h0, 0, 1, 0));
    endtask

    task automatic test_append_get();
        send_op(mk_op(FUNC_APPEND, 32'hFFFF_FFFF, 63, 127, 63));
        send_op(mk_op(FUNC_APPEND, 32'h0000_0000, 0, 0, 0));
        send_op(mk_op(FUNC_APPEND, 32'h1234_5678, 21, 85, 42));
        send_op(mk_op(FUNC_APPEND, 32'h0000_0000, 42, 42, 21));
        send_op(mk_op(FUNC_APPEND, 32'hA5A5_A5A5, 0, 1, 0));
        send_op(mk_op(FUNC_GET, 32'h0, 0, 1, 0));
        send_op(mk_op(FUNC_GET, 32'hFFFF_FFFF, 4, 1, 0));
        send_op(mk_op(FUNC_GET, 32'h0, 5, 1, 0));
        send_op(mk_op(FUNC_GET, 32'h0, 63, 1, 0));
    endtask

    task automatic test_remove();
        send_op(mk_op(FUNC_REMOVE, 32'h0000_0000, 0, 1, 0));
        send_op(mk_op(FUNC_REMOVE, 32'hDEAD_BEEF, 0, 1, 0));
        send_op(mk_op(FUNC_GET, 32'h0, 1, 1, 0));
    endtask

    task automatic test_move();
        send_op(mk_op(FUNC_APPEND, 32'h0F0F_0F0F, 0, 1, 0));
        send_op(mk_op(FUNC_APPEND, 32'hF0F0_F0F0, 0, 1, 0));
        send_op(mk_op(FUNC_MOVE, 32'h0, 1, 2, 3));
        send_op(mk_op(FUNC_MOVE, 32'h0, 4, 2, 0));
        send_op(mk_op(FUNC_MOVE, 32'h0, 2, 2, 2));
        send_op(mk_op(FUNC_MOVE, 32'h0, 1, 0, 2));
        send_op(mk_op(FUNC_MOVE, 32'h0, 6, 1, 0));
        send_op(mk_op(FUNC_MOVE, 32'h0, 0, 1, 6));
        send_op(mk_op(FUNC_MOVE, 32'h0, 3, 4, 0));
        send_op(mk_op(FUNC_MOVE, 32'h0, 0, 2, 5));
        send_op(mk_op(FUNC_MOVE, 32'h0, 0, 127, 0));
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_req = 1'b1;
        repeat (16)
            send_op(pick_op(32));
    endtask

    task automatic test_random_traffic(int n_items, int s_pct, int r_pct);
        int target;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        target = CAPACITY;
        for (int n = 0; n < n_items; n++)
        begin
            if (n % 100 == 0)
            begin
                if (block_idx % 4 == 0)
                    target = CAPACITY;
                else if (block_idx % 4 == 2)
                    target = 0;
                else
                    target = $urandom_range(CAPACITY - 1, 1);
                block_idx++;
            end
            send_op(pick_op(target));
        end
    endtask

    // receiver: random ready, with one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                out_ready <= 1'b0;
                repeat (400) @(negedge clk);
                hold_off_req = 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_reply
        list_reply_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_replies.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected beat: status %0d word %h length %0d",
                             status, read_word, list_length);
            end
            else
            begin
                want = pending_replies.pop_front();
                if (status !== want.st || read_word !== want.word || list_length !== want.len)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: status %0d/%0d word %h/%h length %0d/%0d (exp/act)",
                                 want.st, status, want.word, read_word, want.len, list_length);
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = FUNC_APPEND;
        item_word = '0;
        position = '0;
        move_count = '0;
        destination = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        mismatch_count = 0;
        block_idx = 0;
        hold_off_req = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_empty_list();
        test_append_get();
        test_remove();
        test_move();
        test_backpressure();
        test_random_traffic(530, 29, 86);
        test_random_traffic(530, 86, 29);
        test_random_traffic(540, 0, 0);
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (3 * CAPACITY) @(posedge clk);
        if (mismatch_count == 0 && pending_replies.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/olsu_pkg.sv
design/olsu_cell.sv
design/ordered_list_store_unit.sv
design/olsu_checker.sv
tb/sv/ordered_list_store_unit_tb.sv
